@@ hw/rtl/tgadec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared result codes, queue sizing and the result record type.
// ----------------------------------------------------------------------------
package tgadec_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TYPE  = 2'd1;
  localparam logic [1:0] ERR_DEPTH = 2'd2;

  localparam logic [2:0] BPP_LUMA = 3'd1;
  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_RGBA = 3'd4;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  bpp;
    logic        flip;
    logic [31:0] pixel;
    logic [7:0]  run;
    logic [1:0]  err;
    logic        last;
  } tgadec_rec_t;

endpackage

@@ hw/rtl/tgadec_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder front end
// Parses header bytes and packet bytes, assembles pixels and emits records.
// ----------------------------------------------------------------------------
module tgadec_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output logic               push,
  output tgadec_pkg::tgadec_rec_t rec
);
  import tgadec_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_PACKET, PH_PIXEL, PH_DONE} phase_t;

  localparam logic [4:0] IDX_TYPE     = 5'd2;
  localparam logic [4:0] IDX_WIDTH_LO = 5'd12;
  localparam logic [4:0] IDX_WIDTH_HI = 5'd13;
  localparam logic [4:0] IDX_HEIGHT_LO = 5'd14;
  localparam logic [4:0] IDX_HEIGHT_HI = 5'd15;
  localparam logic [4:0] IDX_DEPTH    = 5'd16;
  localparam logic [4:0] IDX_DESC     = 5'd17;

  localparam logic [7:0] TYPE_RAW_RGB  = 8'd2;
  localparam logic [7:0] TYPE_RAW_GRAY = 8'd3;
  localparam logic [7:0] TYPE_RLE_RGB  = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;
  localparam logic [7:0] DEPTH_8       = 8'd8;
  localparam logic [7:0] DEPTH_24      = 8'd24;
  localparam logic [7:0] DEPTH_32      = 8'd32;
  localparam logic [7:0] DESC_FLIP     = 8'd32;

  phase_t      phase_r, phase_cur, phase_nxt;
  logic [4:0]  idx_r, idx_cur, idx_nxt;
  logic        enc_r, enc_cur, enc_nxt;
  logic [15:0] width_r, width_cur, width_nxt;
  logic [15:0] height_r, height_cur, height_nxt;
  logic [2:0]  bpp_r, bpp_cur, bpp_nxt;
  logic        flip_r, flip_cur, flip_nxt;
  logic [31:0] left_r, left_cur, left_nxt;
  logic [7:0]  pkt_r, pkt_cur, pkt_nxt;
  logic        rep_r, rep_cur, rep_nxt;
  logic [1:0]  bip_r, bip_cur, bip_nxt;
  logic [31:0] asm_r, asm_cur, asm_nxt;
  logic [31:0] asm_new;
  logic [7:0]  run;
  logic        res_v;

  always_comb begin
    if (start_of_file) begin
      phase_cur  = PH_HEADER;
      idx_cur    = '0;
      enc_cur    = 1'b0;
      width_cur  = '0;
      height_cur = '0;
      bpp_cur    = '0;
      flip_cur   = 1'b0;
      left_cur   = '0;
      pkt_cur    = '0;
      rep_cur    = 1'b0;
      bip_cur    = '0;
      asm_cur    = '0;
    end else begin
      phase_cur  = phase_r;
      idx_cur    = idx_r;
      enc_cur    = enc_r;
      width_cur  = width_r;
      height_cur = height_r;
      bpp_cur    = bpp_r;
      flip_cur   = flip_r;
      left_cur   = left_r;
      pkt_cur    = pkt_r;
      rep_cur    = rep_r;
      bip_cur    = bip_r;
      asm_cur    = asm_r;
    end

    phase_nxt  = phase_cur;
    idx_nxt    = idx_cur;
    enc_nxt    = enc_cur;
    width_nxt  = width_cur;
    height_nxt = height_cur;
    bpp_nxt    = bpp_cur;
    flip_nxt   = flip_cur;
    left_nxt   = left_cur;
    pkt_nxt    = pkt_cur;
    rep_nxt    = rep_cur;
    bip_nxt    = bip_cur;
    asm_nxt    = asm_cur;
    asm_new    = asm_cur;
    run        = '0;
    res_v      = 1'b0;
    rec        = '0;

    unique case (phase_cur)
      PH_HEADER: begin
        idx_nxt = idx_cur + 5'd1;
        unique case (idx_cur)
          IDX_TYPE: begin
            if (data_byte == TYPE_RAW_RGB || data_byte == TYPE_RAW_GRAY ||
                data_byte == TYPE_RLE_RGB || data_byte == TYPE_RLE_GRAY) begin
              enc_nxt = (data_byte == TYPE_RLE_RGB || data_byte == TYPE_RLE_GRAY);
            end else begin
              idx_nxt   = idx_cur;
              phase_nxt = PH_DONE;
              res_v     = 1'b1;
              rec.kind  = KIND_ERROR;
              rec.err   = ERR_TYPE;
            end
          end
          IDX_WIDTH_LO: width_nxt[7:0] = data_byte;
          IDX_WIDTH_HI: width_nxt[15:8] = data_byte;
          IDX_HEIGHT_LO: height_nxt[7:0] = data_byte;
          IDX_HEIGHT_HI: height_nxt[15:8] = data_byte;
          IDX_DEPTH: begin
            if (data_byte == DEPTH_8) begin
              bpp_nxt = BPP_LUMA;
            end else if (data_byte == DEPTH_24) begin
              bpp_nxt = BPP_RGB;
            end else if (data_byte == DEPTH_32) begin
              bpp_nxt = BPP_RGBA;
            end else begin
              idx_nxt   = idx_cur;
              phase_nxt = PH_DONE;
              res_v     = 1'b1;
              rec.kind  = KIND_ERROR;
              rec.err   = ERR_DEPTH;
            end
          end
          IDX_DESC: begin
            idx_nxt    = idx_cur;
            flip_nxt   = (data_byte == DESC_FLIP);
            left_nxt   = {16'd0, width_cur} * {16'd0, height_cur};
            bip_nxt    = '0;
            asm_nxt    = '0;
            pkt_nxt    = 8'd1;
            rep_nxt    = 1'b0;
            res_v      = 1'b1;
            rec.kind   = KIND_HEADER;
            rec.width  = width_cur;
            rec.height = height_cur;
            rec.bpp    = bpp_cur;
            rec.flip   = flip_nxt;
            if (width_cur == 16'd0 || height_cur == 16'd0) begin
              phase_nxt = PH_DONE;
              rec.last  = 1'b1;
            end else begin
              phase_nxt = enc_cur ? PH_PACKET : PH_PIXEL;
            end
          end
          default: ;
        endcase
      end
      PH_PACKET: begin
        run = {1'b0, data_byte[6:0]} + 8'd1;
        if ({24'd0, run} > left_cur) begin
          run = left_cur[7:0];
        end
        pkt_nxt   = run;
        rep_nxt   = data_byte[7];
        bip_nxt   = '0;
        asm_nxt   = '0;
        phase_nxt = PH_PIXEL;
      end
      PH_PIXEL: begin
        case (bip_cur)
          2'd0: asm_new[7:0]   = data_byte;
          2'd1: asm_new[15:8]  = data_byte;
          2'd2: asm_new[23:16] = data_byte;
          default: asm_new[31:24] = data_byte;
        endcase
        if (({1'b0, bip_cur} + 3'd1) < bpp_cur) begin
          asm_nxt = asm_new;
          bip_nxt = bip_cur + 2'd1;
        end else begin
          asm_nxt = '0;
          bip_nxt = '0;
          run = (enc_cur && rep_cur) ? pkt_cur : 8'd1;
          if ({24'd0, run} > left_cur) begin
            run = left_cur[7:0];
          end
          left_nxt   = left_cur - {24'd0, run};
          res_v      = 1'b1;
          rec.kind   = KIND_PIXEL;
          rec.width  = width_cur;
          rec.height = height_cur;
          rec.bpp    = bpp_cur;
          rec.flip   = flip_cur;
          rec.pixel  = asm_new;
          rec.run    = run;
          if (enc_cur) begin
            if (rep_cur || pkt_cur <= 8'd1) begin
              pkt_nxt   = '0;
              phase_nxt = PH_PACKET;
            end else begin
              pkt_nxt = pkt_cur - 8'd1;
            end
          end
          if (left_nxt == 32'd0) begin
            phase_nxt = PH_DONE;
            rec.last  = 1'b1;
          end
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    push = accept && res_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      enc_r    <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      flip_r   <= 1'b0;
      left_r   <= '0;
      pkt_r    <= '0;
      rep_r    <= 1'b0;
      bip_r    <= '0;
      asm_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      enc_r    <= enc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      flip_r   <= flip_nxt;
      left_r   <= left_nxt;
      pkt_r    <= pkt_nxt;
      rep_r    <= rep_nxt;
      bip_r    <= bip_nxt;
      asm_r    <= asm_nxt;
    end
  end

endmodule

@@ hw/rtl/tgadec_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder record queue
// Short first-in first-out queue of result records between front and back.
// ----------------------------------------------------------------------------
module tgadec_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  tgadec_pkg::tgadec_rec_t wdata,
  input  logic                    pop,
  output tgadec_pkg::tgadec_rec_t rdata,
  output logic                    full,
  output logic                    empty
);
  import tgadec_pkg::*;

  tgadec_rec_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/tgadec_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA decoder back end
// Unpacks queued records into color channels and holds the output register.
// ----------------------------------------------------------------------------
module tgadec_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tgadec_pkg::tgadec_rec_t rec,
  input  logic                    empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_kind,
  output logic [15:0]             out_image_width,
  output logic [15:0]             out_image_height,
  output logic [2:0]              out_pixel_bytes,
  output logic                    out_flip_rows,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic [7:0]              out_alpha,
  output logic [7:0]              out_run_length,
  output logic [1:0]              out_error_code,
  output logic                    out_last
);
  import tgadec_pkg::*;

  logic       valid_r;
  logic [7:0] red, green, blue, alpha;

  assign pop       = !empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;

  always_comb begin
    if (rec.bpp == BPP_LUMA) begin
      red   = rec.pixel[7:0];
      green = '0;
      blue  = '0;
      alpha = '0;
    end else begin
      red   = rec.pixel[23:16];
      green = rec.pixel[15:8];
      blue  = rec.pixel[7:0];
      alpha = (rec.bpp == BPP_RGBA) ? rec.pixel[31:24] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind         <= rec.kind;
      out_image_width  <= rec.width;
      out_image_height <= rec.height;
      out_pixel_bytes  <= rec.bpp;
      out_flip_rows    <= rec.flip;
      out_red          <= red;
      out_green        <= green;
      out_blue         <= blue;
      out_alpha        <= alpha;
      out_run_length   <= rec.run;
      out_error_code   <= rec.err;
      out_last         <= rec.last;
    end
  end

endmodule

@@ hw/rtl/tga_rle_image_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA run-length image decoder
// Streams a TGA file one byte per item and emits header, pixel run and
// error items.
// ----------------------------------------------------------------------------
// The input channel carries one file byte per item; in_start_of_file marks
// the first byte of a file and restarts the parser. The result channel gives
// one item for the accepted header, one for each pixel or repeated run, and
// one for an error. Both channels use valid and stall.
// One byte is taken every cycle while the queue is not full; the parser
// writes the item of each byte, if any, into a four-entry queue. The queue
// feeds an output register, so an item passes through the queue and then
// the output register before it appears on the result channel.
// When the receiver stalls, items collect in the queue and the output
// register; in_stall rises only once the queue is full, so input flow
// continues through a short stall.
// Reset is synchronous and active low: it empties the queue and the output
// register and returns the parser to the start of a header.
// ----------------------------------------------------------------------------
module tga_rle_image_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [2:0]  out_pixel_bytes,
  output logic        out_flip_rows,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_run_length,
  output logic [1:0]  out_error_code,
  output logic        out_last
);
  import tgadec_pkg::*;

  tgadec_rec_t wrec, rrec;
  logic        accept, push, pop, full, empty;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  tgadec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .start_of_file (in_start_of_file),
    .push          (push),
    .rec           (wrec)
  );

  tgadec_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wrec),
    .pop   (pop),
    .rdata (rrec),
    .full  (full),
    .empty (empty)
  );

  tgadec_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec              (rrec),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_pixel_bytes  (out_pixel_bytes),
    .out_flip_rows    (out_flip_rows),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_run_length   (out_run_length),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule
